>>> src/integral_state_feedback_duty_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the integral state-feedback duty controller
// Short wrappers around concurrent assertions so that each check in the
// design reads as one line. Each one is clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef INTEGRAL_STATE_FEEDBACK_DUTY_ASSERT_SVH
`define INTEGRAL_STATE_FEEDBACK_DUTY_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ISFD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("isfd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ISFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("isfd assertion failed");

`endif

>>> src/isfd_pkg.sv
// ----------------------------------------------------------------------------
// isfd_pkg: shared types and constants
// Data types, register indexes, sequencer step codes and accumulator
// operation codes used across the state-feedback duty controller.
// ----------------------------------------------------------------------------
package isfd_pkg;

    // Data widths.
    localparam int WORD_W   = 32;
    localparam int SP_W     = 17;
    localparam int MUL_W    = 33;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int ACC_W    = 98;
    localparam int SUM_W    = 34;
    localparam int DUTY_W   = 21;
    localparam int X_W      = 31;
    localparam int Q_W      = 20;
    localparam int CFG_IDX_W = 3;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic signed [MUL_W-1:0]  t_mul_op;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic signed [63:0]       t_dword;
    typedef logic [DUTY_W-1:0]        t_duty;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_REF_ANGLE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_K_ANGLE_M1    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_K_RATE_M1     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_K_ANGLE_M2    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_K_RATE_M2     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_KI_M1         = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_KI_M2         = 3'd7;

    localparam logic [SP_W-1:0] SAMPLE_PERIOD_RESET = 17'd655;

    // Sequencer steps, named after the product issued or the result taken in that step.
    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] t_step;
    localparam t_step ST_ERR_MUL = 4'd0;
    localparam t_step ST_KA1     = 4'd1;
    localparam t_step ST_KR1     = 4'd2;
    localparam t_step ST_KIH1    = 4'd3;
    localparam t_step ST_KIL1    = 4'd4;
    localparam t_step ST_KA2     = 4'd5;
    localparam t_step ST_KR2     = 4'd6;
    localparam t_step ST_KIH2    = 4'd7;
    localparam t_step ST_KIL2    = 4'd8;
    localparam t_step ST_SCL1    = 4'd9;
    localparam t_step ST_X1      = 4'd10;
    localparam t_step ST_RCP1    = 4'd11;
    localparam t_step ST_SCL2    = 4'd12;
    localparam t_step ST_X2      = 4'd13;
    localparam t_step ST_RCP2    = 4'd14;
    localparam t_step ST_DUTY2   = 4'd15;
    localparam t_step ST_LAST    = ST_DUTY2;
    localparam t_step STEP_ONE   = 4'd1;

    // Accumulator operations.
    localparam int ACC_OP_W = 3;
    typedef logic [ACC_OP_W-1:0] t_acc_op;
    localparam t_acc_op ACC_HOLD     = 3'd0;
    localparam t_acc_op ACC_LOAD_NEG = 3'd1;
    localparam t_acc_op ACC_SUB      = 3'd2;
    localparam t_acc_op ACC_ADD_HI   = 3'd3;
    localparam t_acc_op ACC_ADD      = 3'd4;

    // Sequencer status handed to the datapath.
    typedef struct packed {
        logic  busy;
        logic  done;
        t_step step;
    } t_seq;

    // Motor mapping constants.
    localparam longint OFF1_E4      = 22374;
    localparam longint OFF2_E4      = 20675;
    localparam longint OFF_DEN      = 10000;
    localparam longint SLOPE1       = 887;
    localparam longint SLOPE2       = 822;
    localparam longint DUTY_SCALE   = 100000000;
    localparam longint DUTY_LO_SPAN = 400000;
    localparam longint DUTY_HI_SPAN = 600001;
    localparam int     RECIP_SHIFT  = 40;
    localparam int     DUTY_BASE    = 1000000;
    localparam int     DUTY_MIN     = 1400000;
    localparam int     DUTY_MAX     = 1600000;

endpackage

>>> src/isfd_mul.sv
// ----------------------------------------------------------------------------
// isfd_mul: shared signed multiplier
// One registered 33 x 33 signed multiplier. The product holds while the
// enable is low so that a result can be consumed late.
// ----------------------------------------------------------------------------
module isfd_mul (
    input  logic               i_clk,
    input  logic               i_en,
    input  isfd_pkg::t_mul_op  i_a,
    input  isfd_pkg::t_mul_op  i_b,
    output isfd_pkg::t_prod    o_prod
);

    isfd_pkg::t_prod r_prod;

    // Register the product of the selected operands.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= isfd_pkg::t_prod'(i_a) * isfd_pkg::t_prod'(i_b);
        end
    end

    assign o_prod = r_prod;

endmodule

>>> src/isfd_acc.sv
// ----------------------------------------------------------------------------
// isfd_acc: wide force accumulator
// Sums the gain products of one motor exactly, then shifts out the
// fractional bits and saturates the force to a signed 32-bit word.
// ----------------------------------------------------------------------------
module isfd_acc #(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  isfd_pkg::t_acc_op   i_op,
    input  isfd_pkg::t_prod     i_prod,
    output isfd_pkg::t_word     o_force
);

    localparam isfd_pkg::t_word WORD_MAX = 32'sh7fffffff;
    localparam isfd_pkg::t_word WORD_MIN = 32'sh80000000;

    isfd_pkg::t_acc r_acc;
    isfd_pkg::t_acc w_term;
    isfd_pkg::t_acc w_shift;

    // The high partial product of the integral term weighs 2^32.
    assign w_term = (i_op == isfd_pkg::ACC_ADD_HI)
                  ? (isfd_pkg::t_acc'(i_prod) <<< 32) : isfd_pkg::t_acc'(i_prod);

    // Accumulate one product per cycle unless the operation is a hold.
    always_ff @(posedge i_clk) begin
        case (i_op)
            isfd_pkg::ACC_LOAD_NEG: r_acc <= -w_term;
            isfd_pkg::ACC_SUB:      r_acc <= r_acc - w_term;
            isfd_pkg::ACC_ADD_HI,
            isfd_pkg::ACC_ADD:      r_acc <= r_acc + w_term;
            default:                r_acc <= r_acc;
        endcase
    end

    // Floor shift and saturate to the force range.
    assign w_shift = r_acc >>> FRAC_BITS;

    always_comb begin
        if (w_shift > isfd_pkg::t_acc'(WORD_MAX)) begin
            o_force = WORD_MAX;
        end else if (w_shift < isfd_pkg::t_acc'(WORD_MIN)) begin
            o_force = WORD_MIN;
        end else begin
            o_force = w_shift[isfd_pkg::WORD_W-1:0];
        end
    end

endmodule

>>> src/isfd_ctrl.sv
// ----------------------------------------------------------------------------
// isfd_ctrl: step sequencer
// Walks one transaction through the sixteen steps of the shared multiplier
// and holds in the last step until the output register is free.
// ----------------------------------------------------------------------------
module isfd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_out_free,
    output isfd_pkg::t_seq  o_seq
);

    logic                r_busy;
    isfd_pkg::t_step     r_step;
    logic                w_done;

    // The transaction completes when the last step can hand off its result.
    assign w_done = r_busy && (r_step == isfd_pkg::ST_LAST) && i_out_free;

    // Step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= isfd_pkg::ST_ERR_MUL;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= isfd_pkg::ST_ERR_MUL;
        end else if (w_done) begin
            r_busy <= 1'b0;
        end else if (r_busy && (r_step != isfd_pkg::ST_LAST)) begin
            r_step <= r_step + isfd_pkg::STEP_ONE;
        end
    end

    assign o_seq.busy = r_busy;
    assign o_seq.done = w_done;
    assign o_seq.step = r_step;

endmodule

>>> src/integral_state_feedback_duty.sv
// ----------------------------------------------------------------------------
// integral_state_feedback_duty: integral state-feedback motor duty controller
// Tracks a pitch reference with a saturating error integrator and maps two
// feedback motor forces to clamped PWM high times.
// ----------------------------------------------------------------------------
// Usage:
// Configuration registers are written through i_cfg_wr_en, i_cfg_index and
// i_cfg_wdata while no transaction is in flight; they take effect at once.
// The input channel (i_valid / o_stall) carries one angle, rate and trim
// sample per transaction. The output channel (o_valid / i_stall) returns one
// transaction with both forces, both duties and both clamp flags.
// Each transaction runs through sixteen steps of one shared 33 x 33
// multiplier: thirteen products plus the accumulate and duty steps. A new
// transaction is not accepted before the previous one completes, but it can
// be accepted in the cycle in which the previous one completes.
// Results park in an output register, so a stalled receiver only delays
// completion of the next transaction, which then waits in its last step.
// Reset is synchronous: it clears the integrator, sets all configuration registers to
// their defaults (sample period 655) and empties the output register.
// ----------------------------------------------------------------------------
`include "integral_state_feedback_duty_assert.svh"

module integral_state_feedback_duty #(
    parameter int FRAC_BITS   = 16,
    parameter int INTEG_WIDTH = 48
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [isfd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [isfd_pkg::WORD_W-1:0]          i_cfg_wdata,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [isfd_pkg::WORD_W-1:0]   i_angle,
    input  logic signed [isfd_pkg::WORD_W-1:0]   i_angle_rate,
    input  logic signed [isfd_pkg::WORD_W-1:0]   i_trim_force,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [isfd_pkg::WORD_W-1:0]   o_force_motor1,
    output logic signed [isfd_pkg::WORD_W-1:0]   o_force_motor2,
    output logic [isfd_pkg::DUTY_W-1:0]          o_duty_motor1,
    output logic [isfd_pkg::DUTY_W-1:0]          o_duty_motor2,
    output logic                                 o_clamped_motor1,
    output logic                                 o_clamped_motor2
);

    // Integrator arithmetic.
    localparam int ISUM_W = isfd_pkg::PROD_W + 1;
    typedef logic signed [INTEG_WIDTH-1:0] t_integ;
    typedef logic signed [ISUM_W-1:0]      t_isum;
    localparam t_isum INTEG_MAX = {{(ISUM_W-INTEG_WIDTH+1){1'b0}}, {(INTEG_WIDTH-1){1'b1}}};
    localparam t_isum INTEG_MIN = {{(ISUM_W-INTEG_WIDTH+1){1'b1}}, {(INTEG_WIDTH-1){1'b0}}};

    // Motor constants in the chosen fixed-point format.
    localparam longint FRAC_SCALE = longint'(1) << FRAC_BITS;
    localparam longint OFF1_VAL =
        (isfd_pkg::OFF1_E4 * FRAC_SCALE + isfd_pkg::OFF_DEN / 2) / isfd_pkg::OFF_DEN;
    localparam longint OFF2_VAL =
        (isfd_pkg::OFF2_E4 * FRAC_SCALE + isfd_pkg::OFF_DEN / 2) / isfd_pkg::OFF_DEN;
    localparam longint S_LO1_VAL = (isfd_pkg::DUTY_LO_SPAN * isfd_pkg::SLOPE1 * FRAC_SCALE
                                   + isfd_pkg::DUTY_SCALE - 1) / isfd_pkg::DUTY_SCALE;
    localparam longint S_HI1_VAL = (isfd_pkg::DUTY_HI_SPAN * isfd_pkg::SLOPE1 * FRAC_SCALE
                                   + isfd_pkg::DUTY_SCALE - 1) / isfd_pkg::DUTY_SCALE;
    localparam longint S_LO2_VAL = (isfd_pkg::DUTY_LO_SPAN * isfd_pkg::SLOPE2 * FRAC_SCALE
                                   + isfd_pkg::DUTY_SCALE - 1) / isfd_pkg::DUTY_SCALE;
    localparam longint S_HI2_VAL = (isfd_pkg::DUTY_HI_SPAN * isfd_pkg::SLOPE2 * FRAC_SCALE
                                   + isfd_pkg::DUTY_SCALE - 1) / isfd_pkg::DUTY_SCALE;
    localparam longint RCP1_VAL = ((longint'(1) << isfd_pkg::RECIP_SHIFT)
                                   + isfd_pkg::SLOPE1 - 1) / isfd_pkg::SLOPE1;
    localparam longint RCP2_VAL = ((longint'(1) << isfd_pkg::RECIP_SHIFT)
                                   + isfd_pkg::SLOPE2 - 1) / isfd_pkg::SLOPE2;

    localparam isfd_pkg::t_sum    OFF1  = isfd_pkg::t_sum'(OFF1_VAL);
    localparam isfd_pkg::t_sum    OFF2  = isfd_pkg::t_sum'(OFF2_VAL);
    localparam isfd_pkg::t_sum    S_LO1 = isfd_pkg::t_sum'(S_LO1_VAL);
    localparam isfd_pkg::t_sum    S_HI1 = isfd_pkg::t_sum'(S_HI1_VAL);
    localparam isfd_pkg::t_sum    S_LO2 = isfd_pkg::t_sum'(S_LO2_VAL);
    localparam isfd_pkg::t_sum    S_HI2 = isfd_pkg::t_sum'(S_HI2_VAL);
    localparam isfd_pkg::t_mul_op RCP1  = isfd_pkg::t_mul_op'(RCP1_VAL);
    localparam isfd_pkg::t_mul_op RCP2  = isfd_pkg::t_mul_op'(RCP2_VAL);
    localparam isfd_pkg::t_mul_op SCALE = isfd_pkg::t_mul_op'(isfd_pkg::DUTY_SCALE);

    // Configuration registers.
    isfd_pkg::t_word             r_ref_angle;
    logic [isfd_pkg::SP_W-1:0]   r_sample_period;
    isfd_pkg::t_word             r_k_angle_m1;
    isfd_pkg::t_word             r_k_rate_m1;
    isfd_pkg::t_word             r_k_angle_m2;
    isfd_pkg::t_word             r_k_rate_m2;
    isfd_pkg::t_word             r_ki_m1;
    isfd_pkg::t_word             r_ki_m2;

    // State and working registers.
    t_integ                      r_integ;
    isfd_pkg::t_word             r_angle;
    isfd_pkg::t_word             r_rate;
    isfd_pkg::t_word             r_trim;
    isfd_pkg::t_word             r_f1;
    isfd_pkg::t_word             r_f2;
    isfd_pkg::t_sum              r_s1;
    isfd_pkg::t_sum              r_s2;
    logic [isfd_pkg::X_W-1:0]    r_x;
    isfd_pkg::t_duty             r_duty1;
    logic                        r_clamp1;

    // Output register.
    logic                        r_out_valid;
    isfd_pkg::t_word             r_out_f1;
    isfd_pkg::t_word             r_out_f2;
    isfd_pkg::t_duty             r_out_duty1;
    isfd_pkg::t_duty             r_out_duty2;
    logic                        r_out_clamp1;
    logic                        r_out_clamp2;

    // Internal nets.
    isfd_pkg::t_seq              w_seq;
    logic                        w_start;
    logic                        w_out_free;
    logic                        w_mul_en;
    isfd_pkg::t_mul_op           w_op_a;
    isfd_pkg::t_mul_op           w_op_b;
    isfd_pkg::t_prod             w_prod;
    isfd_pkg::t_acc_op           w_acc_op;
    isfd_pkg::t_word             w_force;
    isfd_pkg::t_dword            w_integ64;
    t_isum                       w_isum;
    t_integ                      w_integ_next;
    logic                        w_motor2;
    isfd_pkg::t_sum              w_s;
    isfd_pkg::t_sum              w_s_lo;
    isfd_pkg::t_sum              w_s_hi;
    logic [isfd_pkg::Q_W-1:0]    w_q;
    isfd_pkg::t_duty             w_duty;
    logic                        w_clamp;

    // Handshake.
    assign w_out_free = !r_out_valid || !i_stall;
    assign o_stall    = w_seq.busy && !w_seq.done;
    assign w_start    = i_valid && !o_stall;

    isfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_out_free (w_out_free),
        .o_seq      (w_seq)
    );

    isfd_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_a    (w_op_a),
        .i_b    (w_op_b),
        .o_prod (w_prod)
    );

    isfd_acc #(
        .FRAC_BITS (FRAC_BITS)
    ) u_acc (
        .i_clk   (i_clk),
        .i_op    (w_acc_op),
        .i_prod  (w_prod),
        .o_force (w_force)
    );

    // Integrator split into a signed high word and an unsigned low word.
    assign w_integ64 = isfd_pkg::t_dword'(r_integ);

    // Operand selection: at most one product is issued per step; X1, X2 and DUTY2 issue none.
    always_comb begin
        w_mul_en = w_seq.busy;
        w_op_a   = '0;
        w_op_b   = '0;
        case (w_seq.step)
            isfd_pkg::ST_ERR_MUL: begin
                w_op_a = isfd_pkg::t_mul_op'(r_ref_angle) - isfd_pkg::t_mul_op'(r_angle);
                w_op_b = isfd_pkg::t_mul_op'(r_sample_period);
            end
            isfd_pkg::ST_KA1: begin
                w_op_a = isfd_pkg::t_mul_op'(r_k_angle_m1);
                w_op_b = isfd_pkg::t_mul_op'(r_angle);
            end
            isfd_pkg::ST_KR1: begin
                w_op_a = isfd_pkg::t_mul_op'(r_k_rate_m1);
                w_op_b = isfd_pkg::t_mul_op'(r_rate);
            end
            isfd_pkg::ST_KIH1: begin
                w_op_a = isfd_pkg::t_mul_op'(r_ki_m1);
                w_op_b = isfd_pkg::t_mul_op'($signed(w_integ64[63:32]));
            end
            isfd_pkg::ST_KIL1: begin
                w_op_a = isfd_pkg::t_mul_op'(r_ki_m1);
                w_op_b = isfd_pkg::t_mul_op'(w_integ64[31:0]);
            end
            isfd_pkg::ST_KA2: begin
                w_op_a = isfd_pkg::t_mul_op'(r_k_angle_m2);
                w_op_b = isfd_pkg::t_mul_op'(r_angle);
            end
            isfd_pkg::ST_KR2: begin
                w_op_a = isfd_pkg::t_mul_op'(r_k_rate_m2);
                w_op_b = isfd_pkg::t_mul_op'(r_rate);
            end
            isfd_pkg::ST_KIH2: begin
                w_op_a = isfd_pkg::t_mul_op'(r_ki_m2);
                w_op_b = isfd_pkg::t_mul_op'($signed(w_integ64[63:32]));
            end
            isfd_pkg::ST_KIL2: begin
                w_op_a = isfd_pkg::t_mul_op'(r_ki_m2);
                w_op_b = isfd_pkg::t_mul_op'(w_integ64[31:0]);
            end
            isfd_pkg::ST_SCL1: begin
                w_op_a = isfd_pkg::t_mul_op'(r_s1[isfd_pkg::WORD_W-1:0]);
                w_op_b = SCALE;
            end
            isfd_pkg::ST_RCP1: begin
                w_op_a = isfd_pkg::t_mul_op'(r_x);
                w_op_b = RCP1;
            end
            isfd_pkg::ST_SCL2: begin
                w_op_a = isfd_pkg::t_mul_op'(r_s2[isfd_pkg::WORD_W-1:0]);
                w_op_b = SCALE;
            end
            isfd_pkg::ST_RCP2: begin
                w_op_a = isfd_pkg::t_mul_op'(r_x);
                w_op_b = RCP2;
            end
            default: begin
                w_mul_en = 1'b0;
            end
        endcase
    end

    // Accumulator operation: consumes the product issued one step earlier.
    always_comb begin
        w_acc_op = isfd_pkg::ACC_HOLD;
        if (w_seq.busy) begin
            case (w_seq.step)
                isfd_pkg::ST_KR1,  isfd_pkg::ST_KR2:  w_acc_op = isfd_pkg::ACC_LOAD_NEG;
                isfd_pkg::ST_KIH1, isfd_pkg::ST_KIH2: w_acc_op = isfd_pkg::ACC_SUB;
                isfd_pkg::ST_KIL1, isfd_pkg::ST_KIL2: w_acc_op = isfd_pkg::ACC_ADD_HI;
                isfd_pkg::ST_KA2,  isfd_pkg::ST_SCL1: w_acc_op = isfd_pkg::ACC_ADD;
                default:                              w_acc_op = isfd_pkg::ACC_HOLD;
            endcase
        end
    end

    // Saturating integrator update from the error product.
    always_comb begin
        w_isum = t_isum'(r_integ) + t_isum'(w_prod >>> FRAC_BITS);
        if (w_isum > INTEG_MAX) begin
            w_integ_next = INTEG_MAX[INTEG_WIDTH-1:0];
        end else if (w_isum < INTEG_MIN) begin
            w_integ_next = INTEG_MIN[INTEG_WIDTH-1:0];
        end else begin
            w_integ_next = w_isum[INTEG_WIDTH-1:0];
        end
    end

    // Duty mapping. The quotient by the slope comes from a product with the rounded-up
    // reciprocal of the slope; it is only used when the force sum lies inside the duty window.
    assign w_motor2 = (w_seq.step == isfd_pkg::ST_DUTY2);
    assign w_s      = w_motor2 ? r_s2  : r_s1;
    assign w_s_lo   = w_motor2 ? S_LO2 : S_LO1;
    assign w_s_hi   = w_motor2 ? S_HI2 : S_HI1;
    assign w_q      = w_prod[isfd_pkg::RECIP_SHIFT+isfd_pkg::Q_W-1:isfd_pkg::RECIP_SHIFT];

    always_comb begin
        if (w_s < w_s_lo) begin
            w_duty  = isfd_pkg::t_duty'(isfd_pkg::DUTY_MIN);
            w_clamp = 1'b1;
        end else if (w_s >= w_s_hi) begin
            w_duty  = isfd_pkg::t_duty'(isfd_pkg::DUTY_MAX);
            w_clamp = 1'b1;
        end else begin
            w_duty  = isfd_pkg::t_duty'(isfd_pkg::DUTY_BASE) + isfd_pkg::t_duty'(w_q);
            w_clamp = 1'b0;
        end
    end

    // Configuration, integrator and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_angle     <= '0;
            r_sample_period <= isfd_pkg::SAMPLE_PERIOD_RESET;
            r_k_angle_m1    <= '0;
            r_k_rate_m1     <= '0;
            r_k_angle_m2    <= '0;
            r_k_rate_m2     <= '0;
            r_ki_m1         <= '0;
            r_ki_m2         <= '0;
            r_integ         <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    isfd_pkg::REG_REF_ANGLE:     r_ref_angle  <= i_cfg_wdata;
                    isfd_pkg::REG_SAMPLE_PERIOD:
                        r_sample_period <= i_cfg_wdata[isfd_pkg::SP_W-1:0];
                    isfd_pkg::REG_K_ANGLE_M1:    r_k_angle_m1 <= i_cfg_wdata;
                    isfd_pkg::REG_K_RATE_M1:     r_k_rate_m1  <= i_cfg_wdata;
                    isfd_pkg::REG_K_ANGLE_M2:    r_k_angle_m2 <= i_cfg_wdata;
                    isfd_pkg::REG_K_RATE_M2:     r_k_rate_m2  <= i_cfg_wdata;
                    isfd_pkg::REG_KI_M1:         r_ki_m1      <= i_cfg_wdata;
                    isfd_pkg::REG_KI_M2:         r_ki_m2      <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (w_seq.busy && (w_seq.step == isfd_pkg::ST_KA1)) begin
                r_integ <= w_integ_next;
            end
            if (w_seq.done) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers of the datapath.
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_angle <= i_angle;
            r_rate  <= i_angle_rate;
            r_trim  <= i_trim_force;
        end
        if (w_seq.busy) begin
            case (w_seq.step)
                isfd_pkg::ST_KR2: begin
                    r_f1 <= w_force;
                end
                isfd_pkg::ST_KIH2: begin
                    r_s1 <= isfd_pkg::t_sum'(r_f1) + OFF1 + isfd_pkg::t_sum'(r_trim);
                end
                isfd_pkg::ST_X1, isfd_pkg::ST_X2: begin
                    r_x <= w_prod[FRAC_BITS+isfd_pkg::X_W-1:FRAC_BITS];
                    if (w_seq.step == isfd_pkg::ST_X1) begin
                        r_f2 <= w_force;
                    end
                end
                isfd_pkg::ST_RCP1: begin
                    r_s2 <= isfd_pkg::t_sum'(r_f2) + OFF2 + isfd_pkg::t_sum'(r_trim);
                end
                isfd_pkg::ST_SCL2: begin
                    r_duty1  <= w_duty;
                    r_clamp1 <= w_clamp;
                end
                default: ;
            endcase
        end
        if (w_seq.done) begin
            r_out_f1     <= r_f1;
            r_out_f2     <= r_f2;
            r_out_duty1  <= r_duty1;
            r_out_duty2  <= w_duty;
            r_out_clamp1 <= r_clamp1;
            r_out_clamp2 <= w_clamp;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_force_motor1   = r_out_f1;
    assign o_force_motor2   = r_out_f2;
    assign o_duty_motor1    = r_out_duty1;
    assign o_duty_motor2    = r_out_duty2;
    assign o_clamped_motor1 = r_out_clamp1;
    assign o_clamped_motor2 = r_out_clamp2;

    // An accepted transaction always starts at the first step.
    `ISFD_ASSERT_NEXT(a_start_first_step, i_clk, i_rst_n, w_start, w_seq.busy && (w_seq.step == isfd_pkg::ST_ERR_MUL))
    // A completed transaction is presented on the output in the next cycle.
    `ISFD_ASSERT_NEXT(a_done_gives_valid, i_clk, i_rst_n, w_seq.done, o_valid)
    // Presented duties stay inside the clamp window.
    `ISFD_ASSERT_SAME(a_duty_window, i_clk, i_rst_n, o_valid, (o_duty_motor1 >= isfd_pkg::DUTY_MIN) && (o_duty_motor1 <= isfd_pkg::DUTY_MAX) && (o_duty_motor2 >= isfd_pkg::DUTY_MIN) && (o_duty_motor2 <= isfd_pkg::DUTY_MAX))
    // A clamp flag of motor 1 means its duty sits on one of the limits.
    `ISFD_ASSERT_SAME(a_clamp_on_limit, i_clk, i_rst_n, o_valid && o_clamped_motor1, (o_duty_motor1 == isfd_pkg::DUTY_MIN) || (o_duty_motor1 == isfd_pkg::DUTY_MAX))

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for the integral state-feedback duty controller
// Sends angle, rate and trim samples through the valid/stall input channel,
// predicts every result with a cycle-free model of the integrator, the two
// motor forces and the duty mapping, and compares each result field by field.
// Covers reset defaults, gain and reference extremes, random register
// settings with random idling on both sides, duty clamp edges, and long runs
// of the largest integrator increments of each sign.
// ----------------------------------------------------------------------------
module testbench;

    typedef isfd_pkg::t_word t_word;
    typedef isfd_pkg::t_duty t_duty;

    localparam int     FRAC      = 16;
    localparam int     INTEG_W   = 48;
    localparam int     NUM_REGS  = 8;
    localparam longint Q_ONE     = 64'sd1 <<< FRAC;
    localparam longint INTEG_MAX = (64'sd1 <<< (INTEG_W - 1)) - 1;
    localparam longint INTEG_MIN = -INTEG_MAX - 1;
    localparam longint WORD_MAX  = 64'sd2147483647;
    localparam longint WORD_MIN  = -64'sd2147483648;
    localparam t_word  FIELD_MAX = 32'sh7FFFFFFF;
    localparam t_word  FIELD_MIN = 32'sh80000000;
    localparam logic [31:0] PERIOD_MASK = 32'h0001FFFF;

    // Motor mapping: offsets given in 1e-4 N and held in Q16.16 N, slopes in 1e-5 N per microsecond.
    localparam longint OFF_SCALE     = 10000;
    localparam longint OFFSET_M1     = (22374 * Q_ONE + OFF_SCALE / 2) / OFF_SCALE;
    localparam longint OFFSET_M2     = (20675 * Q_ONE + OFF_SCALE / 2) / OFF_SCALE;
    localparam longint SLOPE_M1      = 887;
    localparam longint SLOPE_M2      = 822;
    localparam longint DUTY_SCALE_NS = 100000000;
    localparam longint DUTY_BASE_NS  = 1000000;
    localparam longint DUTY_LOW      = 1400000;
    localparam longint DUTY_HIGH     = 1600000;

    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 100;
    localparam int LIMIT_ITEMS   = 100;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PRINT_LIMIT   = 50;

    typedef struct packed {
        t_word force1;
        t_word force2;
        t_duty duty1;
        t_duty duty2;
        logic  clamp1;
        logic  clamp2;
    } t_result;

    typedef struct packed {
        t_result            res;
        logic signed [63:0] integ;
    } t_tick;

    typedef struct packed {
        logic  clamp;
        t_duty duty;
    } t_duty_out;

    // DUT signals.
    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_wr_en;
    logic [isfd_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [isfd_pkg::WORD_W-1:0]    i_cfg_wdata;
    logic                           i_valid;
    logic                           o_stall;
    t_word                          i_angle;
    t_word                          i_angle_rate;
    t_word                          i_trim_force;
    logic                           o_valid;
    logic                           i_stall = 1'b0;
    t_word                          o_force_motor1;
    t_word                          o_force_motor2;
    t_duty                          o_duty_motor1;
    t_duty                          o_duty_motor2;
    logic                           o_clamped_motor1;
    logic                           o_clamped_motor2;

    // Shadow state of the controller and the results still owed by it.
    logic [31:0] cfg_shadow [NUM_REGS];
    logic [31:0] next_cfg [NUM_REGS];
    longint      err_integral;
    t_result     pending_results [$];
    t_result     want;

    int  error_count = 0;
    int  items_sent = 0;
    int  results_seen = 0;
    int  settings_loaded = 0;
    int  clamps_predicted = 0;
    int  max_hits = 0;
    int  min_hits = 0;
    bit  tx_idle_en = 1'b1;
    bit  rx_idle_en = 1'b1;
    int  tx_quiet = 0;
    int  stall_left = 0;
    int  quiet_left = 0;

    integral_state_feedback_duty #(
        .FRAC_BITS(FRAC),
        .INTEG_WIDTH(INTEG_W)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_index(i_cfg_index),
        .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_angle(i_angle),
        .i_angle_rate(i_angle_rate),
        .i_trim_force(i_trim_force),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_force_motor1(o_force_motor1),
        .o_force_motor2(o_force_motor2),
        .o_duty_motor1(o_duty_motor1),
        .o_duty_motor2(o_duty_motor2),
        .o_clamped_motor1(o_clamped_motor1),
        .o_clamped_motor2(o_clamped_motor2)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Force = ki * integrator - ka * angle - kr * rate, floor-shifted and saturated.
    function automatic t_word motor_force(input t_word ki, input t_word ka, input t_word kr,
                                          input longint integ, input t_word ang,
                                          input t_word rate);
        logic signed [99:0] acc;
        acc = ki * integ - ka * ang - kr * rate;
        acc = acc >>> FRAC;
        if (acc > WORD_MAX) return FIELD_MAX;
        if (acc < WORD_MIN) return FIELD_MIN;
        return t_word'(acc[31:0]);
    endfunction

    // Duty in ns from force plus offset plus trim, floor-divided and clamped.
    function automatic t_duty_out motor_duty(input t_word frc, input t_word trim,
                                             input longint offset, input longint slope);
        t_duty_out r;
        longint    s;
        longint    num;
        longint    den;
        longint    q;
        longint    d;
        s   = longint'(frc) + longint'(trim) + offset;
        num = s * DUTY_SCALE_NS;
        den = slope * Q_ONE;
        q   = num / den;
        if (num % den != 0 && num < 0) q = q - 1;
        d = DUTY_BASE_NS + q;
        r.clamp = 1'b1;
        if (d < DUTY_LOW) d = DUTY_LOW;
        else if (d > DUTY_HIGH) d = DUTY_HIGH;
        else r.clamp = 1'b0;
        r.duty = t_duty'(d);
        return r;
    endfunction

    // One control tick: integrator update, then both forces and duties.
    function automatic t_tick control_step(input t_word ang, input t_word rate,
                                           input t_word trim, input longint integ_in);
        t_tick     o;
        t_duty_out d;
        longint    diff;
        longint    inc;
        longint    integ;
        diff  = longint'($signed(cfg_shadow[isfd_pkg::REG_REF_ANGLE])) - longint'(ang);
        inc   = (diff * longint'(cfg_shadow[isfd_pkg::REG_SAMPLE_PERIOD])) >>> FRAC;
        integ = integ_in;
        if (inc > 0 && integ > INTEG_MAX - inc) integ = INTEG_MAX;
        else if (inc < 0 && integ < INTEG_MIN - inc) integ = INTEG_MIN;
        else integ = integ + inc;
        o.integ = integ;
        o.res.force1 = motor_force($signed(cfg_shadow[isfd_pkg::REG_KI_M1]),
                                   $signed(cfg_shadow[isfd_pkg::REG_K_ANGLE_M1]),
                                   $signed(cfg_shadow[isfd_pkg::REG_K_RATE_M1]),
                                   integ, ang, rate);
        o.res.force2 = motor_force($signed(cfg_shadow[isfd_pkg::REG_KI_M2]),
                                   $signed(cfg_shadow[isfd_pkg::REG_K_ANGLE_M2]),
                                   $signed(cfg_shadow[isfd_pkg::REG_K_RATE_M2]),
                                   integ, ang, rate);
        d = motor_duty(o.res.force1, trim, OFFSET_M1, SLOPE_M1);
        o.res.duty1  = d.duty;
        o.res.clamp1 = d.clamp;
        d = motor_duty(o.res.force2, trim, OFFSET_M2, SLOPE_M2);
        o.res.duty2  = d.duty;
        o.res.clamp2 = d.clamp;
        return o;
    endfunction

    // Mostly values within +/- span, sometimes full range or an extreme.
    function automatic t_word random_field(input int span);
        case ($urandom_range(0, 7))
            0: return t_word'($urandom);
            1: return $urandom_range(0, 1) ? FIELD_MAX : FIELD_MIN;
            default: return t_word'(int'($urandom_range(0, 2 * span)) - span);
        endcase
    endfunction

    // Sample period with junk above bit 16, which the register must drop.
    function automatic logic [31:0] random_period();
        logic [16:0] p;
        case ($urandom_range(0, 7))
            0: p = '0;
            1: p = 17'd65536;
            2: p = 17'($urandom_range(65537, 131071));
            default: p = 17'($urandom_range(1, 6554));
        endcase
        return {15'($urandom), p};
    endfunction

    // Trim that puts one motor's duty at the target, given the current integrator.
    function automatic t_word trim_for_duty(input t_word ang, input t_word rate,
                                            input bit motor2, input longint target);
        t_tick  peek;
        longint frc;
        longint slope;
        longint offset;
        longint s;
        longint t;
        peek   = control_step(ang, rate, '0, err_integral);
        frc    = motor2 ? longint'(peek.res.force2) : longint'(peek.res.force1);
        slope  = motor2 ? SLOPE_M2 : SLOPE_M1;
        offset = motor2 ? OFFSET_M2 : OFFSET_M1;
        s = ((target - DUTY_BASE_NS) * slope * Q_ONE + DUTY_SCALE_NS - 1) / DUTY_SCALE_NS;
        t = s - frc - offset;
        if (t > WORD_MAX) t = WORD_MAX;
        if (t < WORD_MIN) t = WORD_MIN;
        return t_word'(t);
    endfunction

    // Trim choice for random traffic: mostly aimed at or near the duty window.
    function automatic t_word next_trim(input t_word ang, input t_word rate);
        longint target;
        case ($urandom_range(0, 7))
            0: return t_word'($urandom);
            1: return $urandom_range(0, 1) ? FIELD_MAX : FIELD_MIN;
            2: target = DUTY_LOW + longint'($urandom_range(0, 2)) - 1;
            3: target = DUTY_HIGH + longint'($urandom_range(0, 2)) - 1;
            4: target = longint'($urandom_range(1300000, 1700000));
            default: target = longint'($urandom_range(1400000, 1600000));
        endcase
        return trim_for_duty(ang, rate, $urandom_range(0, 1), target);
    endfunction

    // One line per mismatch, up to a limit; every mismatch is counted.
    task automatic report_mismatch(input string what, input longint got, input longint exp_val);
        if (error_count < PRINT_LIMIT)
            $display("ERROR at %0t: %s: got %0d, expected %0d", $time, what, got, exp_val);
        error_count++;
    endtask

    // Send one sample transaction and record its predicted result.
    task automatic send_sample(input t_word ang, input t_word rate, input t_word trim);
        t_tick tick;
        i_angle      <= ang;
        i_angle_rate <= rate;
        i_trim_force <= trim;
        i_valid      <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        tick = control_step(ang, rate, trim, err_integral);
        err_integral = tick.integ;
        pending_results.push_back(tick.res);
        items_sent++;
        clamps_predicted += tick.res.clamp1 + tick.res.clamp2;
        if (tx_idle_en) begin
            if (tx_quiet > 0) begin
                tx_quiet--;
            end else if ($urandom_range(0, 2) == 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
                tx_quiet = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : 0;
            end
        end
    endtask

    // Hold off the sender until every owed result has come back.
    task automatic wait_results_drained();
        int waited;
        i_valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_results.size() != 0) begin
            report_mismatch("results never arrived", 0, pending_results.size());
            pending_results.delete();
        end
    endtask

    // Write all registers from next_cfg once the block is idle.
    task automatic apply_settings();
        wait_results_drained();
        for (int r = 0; r < NUM_REGS; r++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= isfd_pkg::CFG_IDX_W'(r);
            i_cfg_wdata <= next_cfg[r];
            @(posedge i_clk);
            cfg_shadow[r] = (r == isfd_pkg::REG_SAMPLE_PERIOD)
                          ? (next_cfg[r] & PERIOD_MASK) : next_cfg[r];
        end
        i_cfg_wr_en <= 1'b0;
        settings_loaded++;
    endtask

    // Reset values, field extremes and exact duty clamp edges for both motors.
    task automatic test_reset_defaults();
        longint targets [4];
        t_word  ang;
        t_word  rate;
        targets = '{DUTY_LOW - 1, DUTY_LOW, DUTY_HIGH, DUTY_HIGH + 1};
        send_sample('0, '0, '0);
        send_sample(FIELD_MAX, FIELD_MAX, FIELD_MAX);
        send_sample(FIELD_MIN, FIELD_MIN, FIELD_MIN);
        for (int m = 0; m < 2; m++) begin
            for (int k = 0; k < 4; k++) begin
                ang  = random_field(65536);
                rate = random_field(65536);
                send_sample(ang, rate, trim_for_duty(ang, rate, m[0], targets[k]));
            end
        end
    endtask

    // Gains and reference at their extremes, out-of-range and zero periods.
    task automatic test_gain_extremes();
        next_cfg[isfd_pkg::REG_REF_ANGLE]     = FIELD_MAX;
        next_cfg[isfd_pkg::REG_SAMPLE_PERIOD] = 32'd65536;
        next_cfg[isfd_pkg::REG_K_ANGLE_M1]    = FIELD_MIN;
        next_cfg[isfd_pkg::REG_K_RATE_M1]     = FIELD_MAX;
        next_cfg[isfd_pkg::REG_K_ANGLE_M2]    = FIELD_MAX;
        next_cfg[isfd_pkg::REG_K_RATE_M2]     = FIELD_MIN;
        next_cfg[isfd_pkg::REG_KI_M1]         = FIELD_MAX;
        next_cfg[isfd_pkg::REG_KI_M2]         = FIELD_MIN;
        apply_settings();
        send_sample(FIELD_MAX, FIELD_MAX, next_trim(FIELD_MAX, FIELD_MAX));
        send_sample(FIELD_MIN, FIELD_MIN, next_trim(FIELD_MIN, FIELD_MIN));
        send_sample(FIELD_MAX, FIELD_MIN, next_trim(FIELD_MAX, FIELD_MIN));
        send_sample(FIELD_MIN, FIELD_MAX, next_trim(FIELD_MIN, FIELD_MAX));

        // All ones on the period write: only the low 17 bits are kept.
        next_cfg[isfd_pkg::REG_REF_ANGLE]     = FIELD_MIN;
        next_cfg[isfd_pkg::REG_SAMPLE_PERIOD] = 32'hFFFFFFFF;
        next_cfg[isfd_pkg::REG_K_ANGLE_M1]    = FIELD_MAX;
        next_cfg[isfd_pkg::REG_K_RATE_M1]     = FIELD_MIN;
        next_cfg[isfd_pkg::REG_K_ANGLE_M2]    = FIELD_MIN;
        next_cfg[isfd_pkg::REG_K_RATE_M2]     = FIELD_MAX;
        next_cfg[isfd_pkg::REG_KI_M1]         = FIELD_MIN;
        next_cfg[isfd_pkg::REG_KI_M2]         = FIELD_MAX;
        apply_settings();
        send_sample(FIELD_MAX, FIELD_MAX, next_trim(FIELD_MAX, FIELD_MAX));
        send_sample(FIELD_MIN, FIELD_MIN, next_trim(FIELD_MIN, FIELD_MIN));
        send_sample(FIELD_MAX, FIELD_MIN, next_trim(FIELD_MAX, FIELD_MIN));
        send_sample(FIELD_MIN, FIELD_MAX, next_trim(FIELD_MIN, FIELD_MAX));

        // A zero period freezes the integrator; only the integral term drives force.
        next_cfg[isfd_pkg::REG_REF_ANGLE]     = '0;
        next_cfg[isfd_pkg::REG_SAMPLE_PERIOD] = '0;
        for (int k = isfd_pkg::REG_K_ANGLE_M1; k <= isfd_pkg::REG_K_RATE_M2; k++)
            next_cfg[k] = '0;
        next_cfg[isfd_pkg::REG_KI_M1]         = 32'(Q_ONE);
        next_cfg[isfd_pkg::REG_KI_M2]         = 32'(-Q_ONE);
        apply_settings();
        send_sample(FIELD_MIN, '0, '0);
        send_sample(FIELD_MAX, '0, '0);
    endtask

    // Random register settings, each followed by a batch of random samples.
    task automatic test_random_settings();
        t_word ang;
        t_word rate;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            next_cfg[isfd_pkg::REG_REF_ANGLE]     = random_field(131072);
            next_cfg[isfd_pkg::REG_SAMPLE_PERIOD] = random_period();
            for (int k = isfd_pkg::REG_K_ANGLE_M1; k <= isfd_pkg::REG_KI_M2; k++)
                next_cfg[k] = random_field(262144);
            apply_settings();
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                ang  = random_field(131072);
                rate = random_field(1048576);
                send_sample(ang, rate, next_trim(ang, rate));
            end
        end
    endtask

    // Largest increments of each sign, pushing the integrator toward its limits.
    task automatic test_integrator_limits();
        t_word ang;
        t_word rate;
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        next_cfg[isfd_pkg::REG_REF_ANGLE]     = FIELD_MAX;
        next_cfg[isfd_pkg::REG_SAMPLE_PERIOD] = 32'hFFFFFFFF;
        for (int k = isfd_pkg::REG_K_ANGLE_M1; k <= isfd_pkg::REG_KI_M2; k++)
            next_cfg[k] = random_field(262144);
        apply_settings();
        for (int n = 0; n < LIMIT_ITEMS; n++) begin
            ang  = FIELD_MIN + t_word'($urandom_range(0, 255));
            rate = random_field(1048576);
            send_sample(ang, rate, next_trim(ang, rate));
            if (err_integral == INTEG_MAX) max_hits++;
        end

        next_cfg[isfd_pkg::REG_REF_ANGLE] = FIELD_MIN;
        for (int k = isfd_pkg::REG_K_ANGLE_M1; k <= isfd_pkg::REG_KI_M2; k++)
            next_cfg[k] = random_field(262144);
        apply_settings();
        for (int n = 0; n < LIMIT_ITEMS; n++) begin
            ang  = FIELD_MAX - t_word'($urandom_range(0, 255));
            rate = random_field(1048576);
            send_sample(ang, rate, next_trim(ang, rate));
            if (err_integral == INTEG_MIN) min_hits++;
        end
    endtask

    // Receiver stalls in bursts separated by quiet stretches, unless idling is off.
    always @(posedge i_clk) begin
        if (!rx_idle_en) begin
            stall_left = 0;
            quiet_left = 0;
            i_stall <= 1'b0;
        end else begin
            if (stall_left == 0 && quiet_left == 0) begin
                stall_left = $urandom_range(1, 9);
                quiet_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
                                                         : $urandom_range(1, 12);
            end
            if (stall_left != 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else begin
                i_stall <= 1'b0;
                quiet_left--;
            end
        end
    end

    // Compare each accepted result transaction with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending (force_motor1)",
                                o_force_motor1, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_force_motor1 !== want.force1)
                    report_mismatch("force_motor1", o_force_motor1, want.force1);
                if (o_force_motor2 !== want.force2)
                    report_mismatch("force_motor2", o_force_motor2, want.force2);
                if (o_duty_motor1 !== want.duty1)
                    report_mismatch("duty_motor1", o_duty_motor1, want.duty1);
                if (o_duty_motor2 !== want.duty2)
                    report_mismatch("duty_motor2", o_duty_motor2, want.duty2);
                if (o_clamped_motor1 !== want.clamp1)
                    report_mismatch("clamped_motor1", o_clamped_motor1, want.clamp1);
                if (o_clamped_motor2 !== want.clamp2)
                    report_mismatch("clamped_motor2", o_clamped_motor2, want.clamp2);
            end
        end
    end

    // Main sequence.
    initial begin
        i_rst_n      <= 1'b0;
        i_cfg_wr_en  <= 1'b0;
        i_cfg_index  <= '0;
        i_cfg_wdata  <= '0;
        i_valid      <= 1'b0;
        i_angle      <= '0;
        i_angle_rate <= '0;
        i_trim_force <= '0;
        for (int r = 0; r < NUM_REGS; r++) cfg_shadow[r] = '0;
        cfg_shadow[isfd_pkg::REG_SAMPLE_PERIOD] = 32'd655;
        err_integral = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_gain_extremes();
        test_random_settings();
        test_integrator_limits();

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Checked %0d results from %0d samples over %0d register settings.",
                 results_seen, items_sent, settings_loaded);
        $display("Saw %0d clamped duties; integrator held at upper limit %0d, lower %0d times.",
                 clamps_predicted, max_hits, min_hits);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #40000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

>>> integral_state_feedback_duty.f
+incdir+src
src/isfd_pkg.sv
src/isfd_mul.sv
src/isfd_acc.sv
src/isfd_ctrl.sv
src/integral_state_feedback_duty.sv
test/testbench.sv
